FILE: hdl/hdp_pkg.sv
// ----------------------------------------------------------------------------
// hdp_pkg: shared types and constants for the hierarchical depth pyramid
// Operation codes, config indices, the queued command format and field widths.
// ----------------------------------------------------------------------------
package hdp_pkg;

  localparam int unsigned OpW    = 2;
  localparam int unsigned PixW   = 8;
  localparam int unsigned RectW  = 16;
  localparam int unsigned ValW   = 32;
  localparam int unsigned SizeW  = 9;
  localparam int unsigned LevelW = 4;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR = 2'd0,
    OP_WRITE = 2'd1,
    OP_BUILD = 2'd2,
    OP_TEST  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_e;

  // one request as it travels from the front end to the back end
  typedef struct packed {
    op_e              op;
    logic [PixW-1:0]  px;
    logic [PixW-1:0]  py;
    logic [ValW-1:0]  val;
    logic [RectW-1:0] x0;
    logic [RectW-1:0] x1;
    logic [RectW-1:0] y0;
    logic [RectW-1:0] y1;
    logic             empty;  // rectangle is empty: passes without a walk
    logic [4:0]       bits;   // bit length of the smaller extent
  } cmd_t;

  localparam int unsigned CmdW = $bits(cmd_t);

endpackage

FILE: hdl/hdp_front.sv
// ----------------------------------------------------------------------------
// hdp_front: request intake and classification
// Takes requests from the stream, flags empty rectangles, finds the bit
// length of the smaller extent and pushes the command into a small queue.
// ----------------------------------------------------------------------------
module hdp_front import hdp_pkg::*; #(
  parameter int unsigned QDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cmd_t       in_cmd_i,
  output logic       q_valid_o,
  input  logic       q_ready_i,
  output cmd_t       q_cmd_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  cmd_t             q_mem [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             push, pop;
  cmd_t             cls;
  logic [RectW-1:0] ex, ey, ext;

  always_comb begin
    cls       = in_cmd_i;
    cls.empty = (in_cmd_i.x1 <= in_cmd_i.x0) || (in_cmd_i.y1 <= in_cmd_i.y0);
    ex        = in_cmd_i.x1 - in_cmd_i.x0;
    ey        = in_cmd_i.y1 - in_cmd_i.y0;
    ext       = (ex < ey) ? ex : ey;
    cls.bits  = '0;
    for (int i = 0; i < RectW; i++) begin
      if (ext[i]) cls.bits = 5'(i + 1);
    end
  end

  assign in_ready_o = (cnt_q != (PtrW+1)'(QDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_cmd_o    = q_mem[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop)  rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QDepth)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (PtrW+1)'(QDepth)) |-> !push) else $error("push into full queue");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count step");

endmodule

FILE: hdl/hdp_back.sv
// ----------------------------------------------------------------------------
// hdp_back: pyramid store and sequencer
// Runs clear, write, build and test against the single-port depth store.
// Read data is registered; each build cell takes four reads and one write,
// each test cell one read.
// ----------------------------------------------------------------------------
module hdp_back import hdp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned DEPTH_BITS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             mode_i,
  input  logic [SizeW-1:0] width_i,
  input  logic [SizeW-1:0] height_i,
  output logic             busy_o,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  cmd_t             cmd_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output logic             res_pass_o
);

  localparam int unsigned StoreDepth = (MAX_WIDTH * MAX_HEIGHT * 4) / 3 + 1;
  localparam int unsigned AddrW      = $clog2(StoreDepth + 1);
  localparam int unsigned CoW        = 13;  // coordinates up to 8191
  localparam logic [DEPTH_BITS-1:0] AllOnes = '1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLR   = 9'b000000010,
    S_BLVL  = 9'b000000100,
    S_BRD   = 9'b000001000,
    S_BWR   = 9'b000010000,
    S_TSET  = 9'b000100000,
    S_TOFF  = 9'b001000000,
    S_TRD   = 9'b010000000,
    S_TCHK  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [DEPTH_BITS-1:0] mem [StoreDepth];
  logic [DEPTH_BITS-1:0] rdata_q;
  logic                  rd_en, wr_en;
  logic [AddrW-1:0]      addr;
  logic [DEPTH_BITS-1:0] wdata;

  logic [LevelW-1:0] built_q, built_d;
  logic [CoW-1:0]    ew, eh;
  cmd_t              cmd_q, cmd_d;

  // walk registers
  logic [AddrW-1:0]  poff_q, poff_d, coff_q, coff_d, ptr_q, ptr_d;
  logic [CoW-1:0]    pw_q, pw_d, mw_q, mw_d, mh_q, mh_d;
  logic [CoW-1:0]    x_q, x_d, y_q, y_d, xs_q, xs_d, xe_q, xe_d, ye_q, ye_d;
  logic [1:0]        sub_q, sub_d;
  logic              rdv_q;
  logic [DEPTH_BITS-1:0] acc_q, acc_d;
  logic [LevelW-1:0] lvl_q, lvl_d, lk_q, lk_d;
  logic [AddrW-1:0]  row_q, row_d;
  logic              res_valid_q, res_valid_d, res_pass_q, res_pass_d;

  logic [DEPTH_BITS-1:0] v, pk;
  logic [CoW-1:0]    lw, lh;
  logic [RectW-1:0]  x1m, y1m;
  logic [CoW+1:0]    tx0, tx1, ty0, ty1;
  logic [4:0]        lvl_raw;

  always_comb begin
    ew = (width_i == '0) ? CoW'(1) : (CoW'(width_i) > CoW'(MAX_WIDTH) ?
         CoW'(MAX_WIDTH) : CoW'(width_i));
    eh = (height_i == '0) ? CoW'(1) : (CoW'(height_i) > CoW'(MAX_HEIGHT) ?
         CoW'(MAX_HEIGHT) : CoW'(height_i));
  end

  assign v  = cmd_q.val[DEPTH_BITS-1:0];
  assign pk = mode_i ? ((rdata_q > acc_q) ? rdata_q : acc_q)
                     : ((rdata_q < acc_q) ? rdata_q : acc_q);
  assign lw = ew >> lk_q;
  assign lh = eh >> lk_q;
  assign x1m = cmd_q.x1 - 1'b1;
  assign y1m = cmd_q.y1 - 1'b1;
  assign lvl_raw = (cmd_q.bits < 5'd2) ? 5'd0 : cmd_q.bits - 5'd2;

  assign cmd_ready_o = (state_q == S_IDLE) && !res_valid_q;
  assign busy_o      = (state_q != S_IDLE) || res_valid_q;
  assign res_valid_o = res_valid_q;
  assign res_pass_o  = res_pass_q;

  always_comb begin
    state_d = state_q;  built_d = built_q;  cmd_d = cmd_q;
    poff_d = poff_q; coff_d = coff_q; ptr_d = ptr_q; pw_d = pw_q;
    mw_d = mw_q; mh_d = mh_q; x_d = x_q; y_d = y_q;
    xs_d = xs_q; xe_d = xe_q; ye_d = ye_q; sub_d = sub_q; acc_d = acc_q;
    lvl_d = lvl_q; lk_d = lk_q; row_d = row_q;
    res_valid_d = res_valid_q; res_pass_d = res_pass_q;
    rd_en = 1'b0; wr_en = 1'b0; addr = ptr_q; wdata = v;
    tx0 = '0; tx1 = '0; ty0 = '0; ty1 = '0;
    if (res_valid_q && res_ready_i) res_valid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          cmd_d = cmd_i;
          unique case (cmd_i.op)
            OP_CLEAR: begin
              ptr_d = '0; built_d = '0; state_d = S_CLR;
            end
            OP_WRITE: begin
              if (CoW'(cmd_i.px) < ew && CoW'(cmd_i.py) < eh) begin
                wr_en = 1'b1;
                addr  = AddrW'(cmd_i.py) * AddrW'(ew) + AddrW'(cmd_i.px);
                wdata = cmd_i.val[DEPTH_BITS-1:0];
              end
            end
            OP_BUILD: begin
              poff_d = '0; pw_d = ew; mw_d = ew; mh_d = eh;
              built_d = '0; state_d = S_BLVL;
            end
            default: begin
              if (cmd_i.empty) begin
                res_valid_d = 1'b1; res_pass_d = 1'b1;
              end else begin
                state_d = S_TSET;
              end
            end
          endcase
        end
      end
      S_CLR: begin
        wr_en = 1'b1;
        wdata = mode_i ? '0 : AllOnes;
        if (32'(ptr_q) + 1 >= 32'(ew) * 32'(eh)) state_d = S_IDLE;
        ptr_d = ptr_q + 1'b1;
      end
      S_BLVL: begin
        if (mw_q > 1 && mh_q > 1) begin
          coff_d = poff_q + AddrW'(mw_q) * AddrW'(mh_q);
          pw_d = mw_q; mw_d = mw_q >> 1; mh_d = mh_q >> 1;
          x_d = '0; y_d = '0; sub_d = '0;
          row_d = poff_q;
          ptr_d = poff_q + AddrW'(mw_q) * AddrW'(mh_q);
          state_d = S_BRD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_BRD: begin
        // reads r0, r0+1, r1, r1+1 in turn; the value lands in the read data register
        rd_en = 1'b1;
        unique case (sub_q)
          2'd0: addr = row_q + AddrW'({x_q, 1'b0});
          2'd1: addr = row_q + AddrW'({x_q, 1'b0}) + 1'b1;
          2'd2: addr = row_q + AddrW'(pw_q) + AddrW'({x_q, 1'b0});
          default: addr = row_q + AddrW'(pw_q) + AddrW'({x_q, 1'b0}) + 1'b1;
        endcase
        if (sub_q != 2'd0 && rdv_q) acc_d = (sub_q == 2'd1) ? rdata_q : pk;
        sub_d = sub_q + 1'b1;
        if (sub_q == 2'd3) state_d = S_BWR;
      end
      S_BWR: begin
        wr_en = 1'b1;
        addr  = coff_q + AddrW'(y_q) * AddrW'(mw_q) + AddrW'(x_q);
        wdata = pk;
        sub_d = '0;
        state_d = S_BRD;
        if (x_q + 1'b1 == mw_q) begin
          x_d = '0;
          row_d = row_q + AddrW'({pw_q, 1'b0});
          if (y_q + 1'b1 == mh_q) begin
            poff_d = coff_q; built_d = built_q + 1'b1; state_d = S_BLVL;
          end else y_d = y_q + 1'b1;
        end else x_d = x_q + 1'b1;
      end
      S_TSET: begin
        lvl_d = (lvl_raw > 5'(built_q)) ? built_q : lvl_raw[LevelW-1:0];
        lk_d = '0; ptr_d = '0;
        state_d = S_TOFF;
      end
      S_TOFF: begin
        // accumulate the level offset one level a cycle
        if (lk_q == lvl_q) begin
          tx0 = (CoW+2)'(cmd_q.x0 >> lvl_q);
          tx1 = (CoW+2)'(x1m >> lvl_q) + 1'b1;
          ty0 = (CoW+2)'(cmd_q.y0 >> lvl_q);
          ty1 = (CoW+2)'(y1m >> lvl_q) + 1'b1;
          if ((cmd_q.x0 >> lvl_q) > RectW'(lw)) tx0 = (CoW+2)'(lw);
          if ((x1m >> lvl_q) >= RectW'(lw))     tx1 = (CoW+2)'(lw);
          if ((cmd_q.y0 >> lvl_q) > RectW'(lh)) ty0 = (CoW+2)'(lh);
          if ((y1m >> lvl_q) >= RectW'(lh))     ty1 = (CoW+2)'(lh);
          mw_d = lw; xs_d = CoW'(tx0); x_d = CoW'(tx0); xe_d = CoW'(tx1);
          y_d = CoW'(ty0); ye_d = CoW'(ty1);
          row_d = ptr_q + AddrW'(CoW'(ty0)) * AddrW'(lw);
          if (tx0 >= tx1 || ty0 >= ty1) begin
            res_valid_d = 1'b1; res_pass_d = 1'b1; state_d = S_IDLE;
          end else state_d = S_TRD;
        end else begin
          ptr_d = ptr_q + AddrW'(lw) * AddrW'(lh);
          lk_d = lk_q + 1'b1;
        end
      end
      S_TRD: begin
        rd_en = 1'b1;
        addr = row_q + AddrW'(x_q);
        state_d = S_TCHK;
      end
      default: begin  // S_TCHK
        if (mode_i ? (v <= rdata_q) : (v >= rdata_q)) begin
          res_valid_d = 1'b1; res_pass_d = 1'b0; state_d = S_IDLE;
        end else if (x_q + 1'b1 == xe_q) begin
          if (y_q + 1'b1 == ye_q) begin
            res_valid_d = 1'b1; res_pass_d = 1'b1; state_d = S_IDLE;
          end else begin
            y_d = y_q + 1'b1; x_d = xs_q; row_d = row_q + AddrW'(mw_q);
            state_d = S_TRD;
          end
        end else begin
          x_d = x_q + 1'b1; state_d = S_TRD;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && addr < AddrW'(StoreDepth)) mem[addr] <= wdata;
    if (rd_en) rdata_q <= (addr < AddrW'(StoreDepth)) ? mem[addr] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; built_q <= '0; res_valid_q <= 1'b0; rdv_q <= 1'b0;
    end else begin
      state_q <= state_d; built_q <= built_d; res_valid_q <= res_valid_d;
      rdv_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; poff_q <= poff_d; coff_q <= coff_d; ptr_q <= ptr_d;
    pw_q <= pw_d; mw_q <= mw_d; mh_q <= mh_d; x_q <= x_d; y_q <= y_d;
    xs_q <= xs_d; xe_q <= xe_d; ye_q <= ye_d; sub_q <= sub_d; acc_q <= acc_d;
    lvl_q <= lvl_d; lk_q <= lk_d; row_q <= row_d; res_pass_q <= res_pass_d;
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_ready_i) |=> res_valid_q && $stable(res_pass_q))
    else $error("result dropped");
  a_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr_en)) else $error("store port conflict");
  a_lvl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TOFF) |-> lvl_q <= built_q) else $error("level above built");

endmodule

FILE: hdl/hierarchical_depth_pyramid.sv
// ----------------------------------------------------------------------------
// hierarchical_depth_pyramid: min/max depth pyramid with rectangle test
// Front end queues requests, back end runs them on a single-port store.
// ----------------------------------------------------------------------------
// A write is a single store access, a clear writes every base pixel, a build
// reads four cells and writes one on the store port per reduced cell, level
// by level, and a test first steps through the levels below its own for the
// offset, then reads the covered cells; the single store port sets all of these.
// Requests queue two deep ahead of the store sequencer, and a test result
// waits in an output register until taken.
module hierarchical_depth_pyramid import hdp_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned DEPTH_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [8:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,   // op
  // pixel_x, pixel_y, depth_value, rect_min_x, rect_max_x, rect_min_y, rect_max_y
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [7:0]   m_axis_tdata    // test_pass, zero filled
);

  logic             mode_q;
  logic [SizeW-1:0] width_q, height_q;
  cmd_t             in_cmd, q_cmd;
  logic             q_valid, q_ready, busy, pass;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0; width_q <= 9'd256; height_q <= 9'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:   mode_q   <= cfg_data_i[0];
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_cmd       = '0;
    in_cmd.op    = op_e'(s_axis_tuser);
    in_cmd.px    = s_axis_tdata[7:0];
    in_cmd.py    = s_axis_tdata[15:8];
    in_cmd.val   = s_axis_tdata[47:16];
    in_cmd.x0    = s_axis_tdata[63:48];
    in_cmd.x1    = s_axis_tdata[79:64];
    in_cmd.y0    = s_axis_tdata[95:80];
    in_cmd.y1    = s_axis_tdata[111:96];
  end

  hdp_front #(.QDepth(2)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready), .in_cmd_i(in_cmd),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_cmd_o(q_cmd)
  );

  hdp_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
             .DEPTH_BITS(DEPTH_BITS)) u_back (
    .clk_i, .rst_ni,
    .mode_i(mode_q), .width_i(width_q), .height_i(height_q), .busy_o(busy),
    .cmd_valid_i(q_valid), .cmd_ready_o(q_ready), .cmd_i(q_cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_pass_o(pass)
  );

  assign m_axis_tdata = {7'd0, pass};

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request changed while stalled");
  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> busy) else $error("result without busy");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tdata[7:1] == '0) else $error("pad bits set");

endmodule

FILE: sim/hierarchical_depth_pyramid_test.sv
// ----------------------------------------------------------------------------
// hierarchical_depth_pyramid_test: self-checking bench for the depth pyramid
// A directed table, then phases of clear/write/build/test requests under
// random image sizes and depth modes, checked against an in-bench pyramid.
// ----------------------------------------------------------------------------
module hierarchical_depth_pyramid_test;
  import hdp_pkg::*;

  localparam int unsigned STORE_CELLS = (256 * 256 * 4) / 3 + 1;
  localparam int unsigned N_ITEMS     = 1550;
  localparam int unsigned CALM_FROM   = 1400;
  localparam int unsigned WD_LIMIT    = 500000;

  typedef struct packed {
    op_e         op;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [31:0] val;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] y0;
    logic [15:0] y1;
  } req_t;

  typedef struct {
    bit       is_cfg;
    cfg_idx_e idx;
    bit [8:0] data;
    req_t     req;
    bit       typed;
    bit       pass;
  } row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [8:0]   cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [1:0]   s_axis_tuser = '0;
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [7:0]   m_axis_tdata;

  hierarchical_depth_pyramid u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // pyramid mirror
  bit [31:0]   depth_mem [STORE_CELLS];
  bit [3:0]    levels_built;
  bit          mode_max;
  bit [8:0]    width_reg, height_reg;
  bit          pass_q [$];
  int unsigned n_sent, n_tests, n_cfg, n_errors;
  bit          calm;

  function automatic int unsigned clamp_dim(bit [8:0] r);
    if (r < 1) return 1;
    if (r > 256) return 256;
    return r;
  endfunction

  function automatic bit [31:0] mem_rd(int unsigned a);
    return a < STORE_CELLS ? depth_mem[a] : 32'd0;
  endfunction

  function automatic bit [31:0] reduce2(bit [31:0] a, bit [31:0] b);
    if (mode_max) return a > b ? a : b;
    return a < b ? a : b;
  endfunction

  function automatic int unsigned level_base(int unsigned w, int unsigned h, int unsigned l);
    int unsigned off;
    off = 0;
    for (int unsigned k = 0; k < l && k < 31; k++) off += (w >> k) * (h >> k);
    return off;
  endfunction

  task automatic rebuild_levels();
    int unsigned mw, mh, pw, poff, coff, r0, n;
    mw = clamp_dim(width_reg);
    mh = clamp_dim(height_reg);
    poff = 0;
    n = 0;
    while (mw > 1 && mh > 1) begin
      pw = mw;
      coff = poff + mw * mh;
      mw >>= 1;
      mh >>= 1;
      for (int unsigned y = 0; y < mh; y++)
        for (int unsigned x = 0; x < mw; x++) begin
          r0 = poff + 2 * y * pw + 2 * x;
          if (coff + y * mw + x < STORE_CELLS)
            depth_mem[coff + y * mw + x] = reduce2(reduce2(mem_rd(r0), mem_rd(r0 + 1)),
                                                   reduce2(mem_rd(r0 + pw), mem_rd(r0 + pw + 1)));
        end
      poff = coff;
      n++;
    end
    levels_built = 4'(n);
  endtask

  function automatic bit rect_passes(req_t r);
    int unsigned x0, x1, y0, y1, w, h, ext, nb, lvl, mw, mh, off;
    bit [31:0] c;
    x0 = r.x0; x1 = r.x1; y0 = r.y0; y1 = r.y1;
    if (x1 <= x0 || y1 <= y0) return 1'b1;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    ext = (x1 - x0) < (y1 - y0) ? x1 - x0 : y1 - y0;
    nb = 0;
    while (ext != 0) begin nb++; ext >>= 1; end
    lvl = nb < 2 ? 0 : nb - 2;
    if (lvl > levels_built) lvl = levels_built;
    mw = w >> lvl;
    mh = h >> lvl;
    off = level_base(w, h, lvl);
    x0 = x0 >> lvl; x1 = ((x1 - 1) >> lvl) + 1;
    y0 = y0 >> lvl; y1 = ((y1 - 1) >> lvl) + 1;
    if (x0 > mw) x0 = mw;
    if (x1 > mw) x1 = mw;
    if (y0 > mh) y0 = mh;
    if (y1 > mh) y1 = mh;
    for (int unsigned y = y0; y < y1; y++)
      for (int unsigned x = x0; x < x1; x++) begin
        c = mem_rd(off + y * mw + x);
        if (mode_max ? (r.val <= c) : (r.val >= c)) return 1'b0;
      end
    return 1'b1;
  endfunction

  // returns 1 when the request yields a result, which lands in pass
  task automatic apply_req(req_t r, output bit has_res, output bit pass);
    int unsigned w, h;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    has_res = 1'b0;
    pass = 1'b0;
    case (r.op)
      OP_CLEAR: begin
        for (int unsigned i = 0; i < w * h; i++) depth_mem[i] = mode_max ? 32'd0 : '1;
        levels_built = 0;
      end
      OP_WRITE: if (r.px < w && r.py < h) depth_mem[r.py * w + r.px] = r.val;
      OP_BUILD: rebuild_levels();
      default: begin
        has_res = 1'b1;
        pass = rect_passes(r);
      end
    endcase
  endtask

  // ---------------------------------------------------------------- drivers
  task automatic send_req(req_t r, bit typed, bit typed_pass);
    int unsigned gap;
    bit has_res, pass;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      @(negedge clk_i) s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {r.y1, r.y0, r.x1, r.x0, r.val, r.py, r.px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_req(r, has_res, pass);
    if (has_res) pass_q.push_back(typed ? typed_pass : pass);
    n_sent++;
  endtask

  // the last request before this is always a test, so its result marks the
  // end of all earlier work
  task automatic settle();
    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    wait (pass_q.size() == 0);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, bit [8:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_MODE:  mode_max = data[0];
      CFG_WIDTH: width_reg = data;
      default:   height_reg = data;
    endcase
    n_cfg++;
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  // result side stalls in bursts
  int unsigned stall_left;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result check and stall watchdog
  int unsigned idle_cycles;
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pass_q.size() == 0) begin
        $error("test_pass: result with none expected, actual %0d", m_axis_tdata[0]);
        n_errors++;
      end else begin
        if (m_axis_tdata[0] !== pass_q[0]) begin
          $error("test_pass: expected %0d, actual %0d", pass_q[0], m_axis_tdata[0]);
          n_errors++;
        end
        void'(pass_q.pop_front());
        n_tests++;
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else if (idle_cycles + 1 >= WD_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WD_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // ---------------------------------------------------------------- stimulus
  function automatic row_t mk(op_e op, bit [7:0] px, bit [7:0] py, bit [31:0] val,
                              bit [15:0] x0, bit [15:0] x1, bit [15:0] y0,
                              bit [15:0] y1, bit typed = 0, bit pass = 0);
    row_t r;
    r = '{is_cfg: 0, idx: CFG_MODE, data: 0, req: '{op, px, py, val, x0, x1, y0, y1},
          typed: typed, pass: pass};
    return r;
  endfunction

  function automatic row_t mk_cfg(cfg_idx_e idx, bit [8:0] data);
    row_t r;
    r = mk(OP_TEST, 0, 0, 0, 0, 0, 0, 0);
    r.is_cfg = 1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic bit [31:0] pick_depth();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return '1;
      2: return $urandom_range(0, 15);
      3: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t rand_req(op_e op, int unsigned w, int unsigned h);
    req_t r;
    int unsigned len;
    r = req_t'($bits(req_t)'({$urandom, $urandom, $urandom, $urandom}));
    r.op = op;
    if ($urandom_range(0, 9) == 0) return r;  // raw fields
    r.px = 8'($urandom_range(0, w - 1));
    r.py = 8'($urandom_range(0, h - 1));
    r.val = pick_depth();
    len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2 * w) : $urandom_range(0, 4);
    r.x0 = 16'($urandom_range(0, w + 1));
    r.x1 = r.x0 + 16'(len);
    len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 2 * h) : $urandom_range(0, 4);
    r.y0 = 16'($urandom_range(0, h + 1));
    r.y1 = r.y0 + 16'(len);
    return r;
  endfunction

  row_t        dir_rows [$];
  req_t        r;
  int unsigned w, h, k, n_phase;
  bit          heavy;

  initial begin
    width_reg = 256;
    height_reg = 256;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // full-size clear and build first: every cell the pyramid uses is defined from here on
    dir_rows.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(OP_TEST, 0, 0, 32'hFFFF_FFFE, 0, 2, 0, 2, 1, 1));
    dir_rows.push_back(mk(OP_TEST, 0, 0, '1, 254, 256, 254, 256, 1, 0));
    dir_rows.push_back(mk(OP_WRITE, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(OP_WRITE, 255, 255, 5, 0, 0, 0, 0));
    dir_rows.push_back(mk(OP_WRITE, 128, 7, 32'h8000_0000, 0, 0, 0, 0));
    dir_rows.push_back(mk(OP_BUILD, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(OP_TEST, 0, 0, 0, 0, 256, 0, 256, 1, 0));
    dir_rows.push_back(mk(OP_TEST, 0, 0, '1, 16'hFFFF, 0, 0, 1, 1, 1));
    dir_rows.push_back(mk(OP_TEST, 0, 0, '1, 0, 1, 5, 5, 1, 1));
    dir_rows.push_back(mk(OP_TEST, 0, 0, 0, 16'hFFFE, 16'hFFFF, 0, 1));
    dir_rows.push_back(mk(OP_TEST, 0, 0, 0, 0, 1, 0, 1, 1, 0));
    dir_rows.push_back(mk(OP_TEST, 0, 0, 4, 255, 256, 255, 256, 1, 1));
    dir_rows.push_back(mk(OP_TEST, 0, 0, 5, 255, 256, 255, 256, 1, 0));
    dir_rows.push_back(mk(OP_TEST, 0, 0, 1, 16, 48, 16, 48));
    dir_rows.push_back(mk_cfg(CFG_MODE, 1));
    dir_rows.push_back(mk(OP_TEST, 0, 0, 1, 0, 2, 0, 2));
    dir_rows.push_back(mk_cfg(CFG_HEIGHT, 1));  // sizes now stale vs. built levels
    dir_rows.push_back(mk(OP_TEST, 0, 0, '1, 0, 64, 0, 64));
    dir_rows.push_back(mk_cfg(CFG_WIDTH, 0));
    dir_rows.push_back(mk_cfg(CFG_HEIGHT, 511));
    dir_rows.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(OP_WRITE, 255, 3, 9, 0, 0, 0, 0));  // off image, dropped
    dir_rows.push_back(mk(OP_BUILD, 0, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk(OP_TEST, 0, 0, 1, 0, 1, 0, 8));
    dir_rows.push_back(mk_cfg(CFG_WIDTH, 511));
    dir_rows.push_back(mk(OP_TEST, 0, 0, '1, 0, 300, 100, 102));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        settle();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else
        send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].pass);
    end

    // random phases: clear, fill, build (small sizes), then tests and other requests
    n_phase = 0;
    while (n_sent < N_ITEMS) begin
      settle();
      write_reg(CFG_MODE, 9'($urandom_range(0, 1)));
      heavy = $urandom_range(0, 29) == 0;
      write_reg(CFG_WIDTH, heavy ? 9'($urandom_range(0, 511)) : 9'($urandom_range(1, 16)));
      write_reg(CFG_HEIGHT, $urandom_range(0, 5) == 0 ? 9'($urandom_range(0, 511))
                                                    : 9'($urandom_range(1, 16)));
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      heavy = w * h > 1024;
      n_phase++;
      if (!heavy) send_req(rand_req(OP_CLEAR, w, h), 0, 0);
      k = $urandom_range(1, w * h > 24 ? 24 : w * h);
      repeat (k) send_req(rand_req(OP_WRITE, w, h), 0, 0);
      if (!heavy) send_req(rand_req(OP_BUILD, w, h), 0, 0);
      repeat ($urandom_range(10, 30)) begin
        case ($urandom_range(0, 19))
          0:       r = rand_req(heavy ? OP_WRITE : OP_CLEAR, w, h);
          1, 2:    r = rand_req(heavy ? OP_WRITE : OP_BUILD, w, h);
          3, 4, 5: r = rand_req(OP_WRITE, w, h);
          default: r = rand_req(OP_TEST, w, h);
        endcase
        send_req(r, 0, 0);
      end
      calm = n_sent >= CALM_FROM;
      send_req(rand_req(OP_TEST, w, h), 0, 0);
    end

    @(negedge clk_i) s_axis_tvalid <= 1'b0;
    wait (pass_q.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("covered %0d requests in %0d random phases, %0d register writes",
             n_sent, n_phase, n_cfg);
    $display("%0d test results checked, %0d mismatches", n_tests, n_errors);
    if (n_errors == 0 && pass_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
